### src/sts_pkg.sv
// shared types, codes and character helpers for the s-expression token scanner
package sts_pkg;

	// scan mode codes
	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_NUMBER = 2'd1;
	localparam logic [1:0] MODE_IDENT  = 2'd2;
	localparam logic [1:0] MODE_STRING = 2'd3;

	// token kinds
	localparam logic [2:0] KIND_LPAREN = 3'd3;
	localparam logic [2:0] KIND_RPAREN = 3'd4;

	// characters the scanner reacts to
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_VT     = 8'd11;
	localparam logic [7:0] CH_FF     = 8'd12;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_QUOTE  = 8'd34;
	localparam logic [7:0] CH_HASH   = 8'd35;
	localparam logic [7:0] CH_LPAREN = 8'd40;
	localparam logic [7:0] CH_RPAREN = 8'd41;
	localparam logic [7:0] CH_DOT    = 8'd46;
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_NINE   = 8'd57;
	localparam logic [7:0] CH_BSLASH = 8'd92;
	localparam logic [7:0] CH_LOW_F  = 8'd102;
	localparam logic [7:0] CH_LOW_N  = 8'd110;
	localparam logic [7:0] CH_LOW_R  = 8'd114;
	localparam logic [7:0] CH_LOW_T  = 8'd116;
	localparam logic [7:0] CH_LOW_V  = 8'd118;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic [7:0] token_char;
		logic [2:0] token_kind;
		logic       token_end;
	} result_t;

	// all results caused by one source byte
	typedef struct packed {
		logic [1:0]       count;
		result_t [1:0]    res;
	} pkt_t;

	function automatic logic is_ws(input logic [7:0] c);
		return c == CH_TAB || c == CH_CR || c == CH_FF || c == CH_LF || c == CH_SPACE;
	endfunction

	function automatic logic is_paren(input logic [7:0] c);
		return c == CH_LPAREN || c == CH_RPAREN;
	endfunction

	function automatic logic is_dec_char(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic [7:0] translate(input logic [7:0] c);
		logic [7:0] t;
		case (c)
			CH_LOW_N: t = CH_LF;
			CH_LOW_T: t = CH_TAB;
			CH_LOW_R: t = CH_CR;
			CH_LOW_F: t = CH_FF;
			CH_LOW_V: t = CH_VT;
			default:  t = c;
		endcase
		return t;
	endfunction

	function automatic logic [2:0] mode_kind(input logic [1:0] m);
		return {1'b0, m - 2'd1};
	endfunction

	function automatic result_t make_res(input logic [7:0] ch, input logic [2:0] kind,
		input logic last);
		result_t r;
		r.token_char = ch;
		r.token_kind = kind;
		r.token_end  = last;
		return r;
	endfunction

endpackage

### src/sts_if.sv
// handshake channels of the token scanner: source bytes, result packets, token words
interface sts_src_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_char;
	logic       end_of_source;
	modport source(output valid, source_char, end_of_source, input ready);
	modport sink(input valid, source_char, end_of_source, output ready);
endinterface

interface sts_pkt_if;
	logic           valid;
	logic           ready;
	sts_pkg::pkt_t  pkt;
	modport source(output valid, pkt, input ready);
	modport sink(input valid, pkt, output ready);
endinterface

interface sts_tok_if;
	logic       valid;
	logic       ready;
	logic [7:0] token_char;
	logic [2:0] token_kind;
	logic       token_end;
	logic       run_last;
	modport source(output valid, token_char, token_kind, token_end, run_last, input ready);
	modport sink(input valid, token_char, token_kind, token_end, run_last, output ready);
endinterface

### src/sts_front.sv
// front end: takes source bytes, tracks the scan state and forms result packets
module sts_front (
	input logic          clk,
	input logic          arst_n,
	sts_src_if.sink      src,
	sts_pkt_if.source    pkt
);
	import sts_pkg::*;

	logic [1:0] mode_q, mode_d;
	logic       esc_q, esc_d;
	logic       cmt_q, cmt_d;
	logic [7:0] hc_q, hc_d;
	logic       hv_q, hv_d;
	pkt_t       pkt_d;
	logic       accept;

	always_comb begin
		logic [7:0] c;
		logic [7:0] app_c;
		logic       do_scan;
		logic       fin;
		logic       idle;
		logic       app;
		logic [1:0] cnt;

		mode_d  = mode_q;
		esc_d   = esc_q;
		cmt_d   = cmt_q;
		hc_d    = hc_q;
		hv_d    = hv_q;
		pkt_d   = '0;
		cnt     = 2'd0;
		c       = src.source_char;
		app_c   = c;
		do_scan = 1'b0;
		fin     = 1'b0;
		idle    = 1'b0;
		app     = 1'b0;

		// comment skip up to newline
		if (cmt_q) begin
			if (c == CH_LF) begin
				cmt_d   = 1'b0;
				do_scan = 1'b1;
			end
		end else if (c == CH_HASH && mode_q != MODE_STRING) begin
			cmt_d = 1'b1;
		end else begin
			do_scan = 1'b1;
		end

		if (do_scan) begin
			case (mode_q)
				MODE_IDLE: idle = 1'b1;
				MODE_STRING: begin
					if (esc_q) begin
						esc_d = 1'b0;
						app   = 1'b1;
						app_c = translate(c);
					end else if (c == CH_QUOTE) begin
						fin = 1'b1;
					end else if (c == CH_BSLASH) begin
						esc_d = 1'b1;
					end else begin
						app = 1'b1;
					end
				end
				MODE_NUMBER, MODE_IDENT: begin
					if (!is_ws(c) && !is_paren(c)) begin
						// a non-number char ends the number and is rescanned
						if (mode_q == MODE_NUMBER && !is_dec_char(c) && c != CH_DOT) begin
							fin  = 1'b1;
							idle = 1'b1;
						end else begin
							app = 1'b1;
						end
					end else begin
						fin  = 1'b1;
						idle = is_paren(c);
					end
				end
				default: idle = 1'b1;
			endcase
		end

		if (fin) begin
			if (hv_d && mode_d != MODE_IDLE) begin
				pkt_d.res[cnt[0]] = make_res(hc_d, mode_kind(mode_d), 1'b1);
				cnt = cnt + 2'd1;
			end
			hv_d   = 1'b0;
			mode_d = MODE_IDLE;
			esc_d  = 1'b0;
		end

		if (idle) begin
			if (is_dec_char(c)) begin
				mode_d = MODE_NUMBER;
				app    = 1'b1;
			end else if (is_ws(c)) begin
				mode_d = MODE_IDLE;
			end else if (c == CH_LPAREN) begin
				pkt_d.res[cnt[0]] = make_res(c, KIND_LPAREN, 1'b1);
				cnt = cnt + 2'd1;
			end else if (c == CH_RPAREN) begin
				pkt_d.res[cnt[0]] = make_res(c, KIND_RPAREN, 1'b1);
				cnt = cnt + 2'd1;
			end else if (c == CH_QUOTE) begin
				mode_d = MODE_STRING;
				hv_d   = 1'b0;
			end else begin
				mode_d = MODE_IDENT;
				app    = 1'b1;
			end
		end

		// held char goes out once its successor is known
		if (app) begin
			if (hv_d) begin
				pkt_d.res[cnt[0]] = make_res(hc_d, mode_kind(mode_d), 1'b0);
				cnt = cnt + 2'd1;
			end
			hc_d = app_c;
			hv_d = 1'b1;
		end

		if (src.end_of_source) begin
			if (hv_d && mode_d != MODE_IDLE) begin
				pkt_d.res[cnt[0]] = make_res(hc_d, mode_kind(mode_d), 1'b1);
				cnt = cnt + 2'd1;
			end
			hv_d   = 1'b0;
			mode_d = MODE_IDLE;
			esc_d  = 1'b0;
			cmt_d  = 1'b0;
		end

		pkt_d.count = cnt;
	end

	assign src.ready = pkt.ready;
	assign accept    = src.valid && src.ready;
	assign pkt.valid = accept && pkt_d.count != 2'd0;
	assign pkt.pkt   = pkt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			esc_q  <= 1'b0;
			cmt_q  <= 1'b0;
			hc_q   <= 8'd0;
			hv_q   <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
			cmt_q  <= cmt_d;
			hc_q   <= hc_d;
			hv_q   <= hv_d;
		end
	end

endmodule

### src/sts_queue.sv
// small packet queue between the front end and the output side
module sts_queue #(
	parameter int DEPTH = sts_pkg::QUEUE_DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	sts_pkt_if.sink      wr,
	sts_pkt_if.source    rd
);
	import sts_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pkt_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign wr.ready = cnt_q != CNT_W'(DEPTH);
	assign rd.valid = cnt_q != '0;
	assign rd.pkt   = mem_q[rd_ptr_q];
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr.pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### src/sts_back.sv
// output side: splits packets into token words behind an output register
module sts_back (
	input logic          clk,
	input logic          arst_n,
	sts_pkt_if.sink      pkt,
	sts_tok_if.source    tok
);
	import sts_pkg::*;

	logic    ov_q;
	logic    sec_q;
	result_t out_q;
	logic    last_q;
	result_t hold_q;
	logic    load;

	assign load      = !ov_q || tok.ready;
	assign pkt.ready = load && !sec_q;

	assign tok.valid      = ov_q;
	assign tok.token_char = out_q.token_char;
	assign tok.token_kind = out_q.token_kind;
	assign tok.token_end  = out_q.token_end;
	assign tok.run_last   = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (sec_q) begin
				out_q  <= hold_q;
				last_q <= 1'b1;
			end else if (pkt.valid) begin
				out_q  <= pkt.pkt.res[0];
				last_q <= pkt.pkt.count == 2'd1;
				hold_q <= pkt.pkt.res[1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			sec_q <= 1'b0;
		end else if (load) begin
			if (sec_q) begin
				ov_q  <= 1'b1;
				sec_q <= 1'b0;
			end else if (pkt.valid) begin
				ov_q  <= 1'b1;
				// second word of a two-word packet follows next
				sec_q <= pkt.pkt.count == 2'd2;
			end else begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

### src/sexpr_token_scanner_core.sv
// Streaming s-expression lexer: one source byte in per word, token characters out.
// The front end takes one source byte every cycle while its packet queue has room;
// its whole scan-state update (mode, escape, comment, held character) is registered
// on each accepted byte, so a byte can follow in the next cycle. A byte causes
// zero, one or two token words, which pass through a QUEUE_DEPTH-entry packet queue
// to the output side; that side sends one token word per cycle from a registered
// output while the sink is ready, two words of one byte in turn. Results are
// registered in the packet queue, then in the output register. The last character
// of each token is held back until the next byte shows that the token has ended.
module sexpr_token_scanner_core #(
	parameter int QUEUE_DEPTH = sts_pkg::QUEUE_DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	sts_src_if.sink      src,
	sts_tok_if.source    tok
);
	import sts_pkg::*;

	sts_pkt_if front_pkt ();
	sts_pkt_if back_pkt ();

	sts_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.pkt    (front_pkt)
	);

	sts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_pkt),
		.rd     (back_pkt)
	);

	sts_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (back_pkt),
		.tok    (tok)
	);

endmodule

### verif/sexpr_token_scanner_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the s-expression token scanner: directed and random text, predicted token words
module sexpr_token_scanner_core_tb;
	import sts_pkg::*;

	localparam logic [2:0] KIND_NUMBER = 3'd0;
	localparam logic [2:0] KIND_IDENT  = 3'd1;
	localparam logic [2:0] KIND_STRING = 3'd2;
	localparam logic [2:0] KIND_NONE   = 3'd7;
	localparam int RANDOM_BYTES = 1500;
	localparam int STALL_LIMIT  = 1000;

	typedef struct packed {
		logic [7:0] ch;
		logic       eos;
	} src_byte_t;

	typedef struct packed {
		logic [7:0] token_char;
		logic [2:0] token_kind;
		logic       token_end;
		logic       run_last;
	} token_word_t;

	logic clk;
	logic arst_n;

	sts_src_if src_ch();
	sts_tok_if tok_ch();

	sexpr_token_scanner_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_ch),
		.tok    (tok_ch)
	);

	src_byte_t   source_text[$];
	token_word_t words_due[$];
	token_word_t step_words[$];

	// lexer state of the predictor
	logic [1:0] lex_mode    = MODE_IDLE;
	logic       lex_escape  = 1'b0;
	logic       lex_comment = 1'b0;
	logic [7:0] held_ch     = 8'd0;
	logic       held_ok     = 1'b0;

	int live_bytes;
	int fail_count;
	int bytes_fed;
	int words_checked;
	int tokens_closed;
	int flushes;
	int src_gap;
	int sink_stall;
	int idle_cycles;
	bit src_calm;
	bit sink_calm;
	src_byte_t next_byte;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_TAB || c == CH_LF || c == CH_FF || c == CH_CR || c == CH_SPACE;
	endfunction

	function automatic bit is_paren_char(input logic [7:0] c);
		return c == CH_LPAREN || c == CH_RPAREN;
	endfunction

	function automatic bit is_decimal(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic [7:0] unescape(input logic [7:0] c);
		case (c)
			CH_LOW_N: return CH_LF;
			CH_LOW_T: return CH_TAB;
			CH_LOW_R: return CH_CR;
			CH_LOW_F: return CH_FF;
			CH_LOW_V: return CH_VT;
			default:  return c;
		endcase
	endfunction

	function automatic logic [2:0] kind_of(input logic [1:0] m);
		case (m)
			MODE_NUMBER: return KIND_NUMBER;
			MODE_IDENT:  return KIND_IDENT;
			MODE_STRING: return KIND_STRING;
			default:     return KIND_NONE;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic put_word(input logic [7:0] c, input logic [2:0] kind, input logic last);
		token_word_t w;
		w.token_char = c;
		w.token_kind = kind;
		w.token_end  = last;
		w.run_last   = 1'b0;
		step_words = {step_words, w};
	endtask

	// emit the previously held character, hold the new one
	task automatic keep_char(input logic [7:0] c);
		if (held_ok)
			put_word(held_ch, kind_of(lex_mode), 1'b0);
		held_ch = c;
		held_ok = 1'b1;
	endtask

	task automatic close_token();
		if (held_ok && lex_mode != MODE_IDLE)
			put_word(held_ch, kind_of(lex_mode), 1'b1);
		held_ok    = 1'b0;
		lex_mode   = MODE_IDLE;
		lex_escape = 1'b0;
	endtask

	task automatic start_token(input logic [7:0] c);
		if (is_decimal(c)) begin
			lex_mode = MODE_NUMBER;
			keep_char(c);
		end else if (is_blank(c)) begin
		end else if (c == CH_LPAREN) begin
			put_word(c, KIND_LPAREN, 1'b1);
		end else if (c == CH_RPAREN) begin
			put_word(c, KIND_RPAREN, 1'b1);
		end else if (c == CH_QUOTE) begin
			lex_mode = MODE_STRING;
			held_ok  = 1'b0;
		end else begin
			lex_mode = MODE_IDENT;
			keep_char(c);
		end
	endtask

	task automatic scan_char(input logic [7:0] c);
		if (lex_mode == MODE_IDLE) begin
			start_token(c);
		end else if (lex_mode == MODE_STRING) begin
			if (lex_escape) begin
				lex_escape = 1'b0;
				keep_char(unescape(c));
			end else if (c == CH_QUOTE) begin
				close_token();
			end else if (c == CH_BSLASH) begin
				lex_escape = 1'b1;
			end else begin
				keep_char(c);
			end
		end else if (!is_blank(c) && !is_paren_char(c)) begin
			// a number ends at anything but a digit or a dot; that byte starts over
			if (lex_mode == MODE_NUMBER && !is_decimal(c) && c != CH_DOT) begin
				close_token();
				start_token(c);
			end else begin
				keep_char(c);
			end
		end else if (is_paren_char(c)) begin
			close_token();
			start_token(c);
		end else begin
			close_token();
		end
	endtask

	task automatic lex_byte(input logic [7:0] c, input logic eos);
		token_word_t w;
		step_words.delete();
		if (lex_comment) begin
			if (c == CH_LF) begin
				lex_comment = 1'b0;
				scan_char(c);
			end
		end else if (c == CH_HASH && lex_mode != MODE_STRING) begin
			lex_comment = 1'b1;
		end else begin
			scan_char(c);
		end
		if (eos) begin
			close_token();
			lex_comment = 1'b0;
		end
		for (int i = 0; i < step_words.size(); i++) begin
			w = step_words[i];
			w.run_last = (i == step_words.size() - 1);
			words_due = {words_due, w};
		end
	endtask

	task automatic check_word(input token_word_t got);
		token_word_t want;
		words_checked++;
		if (got.token_end)
			tokens_closed++;
		if (words_due.size() == 0) begin
			$error("token word 0x%02h with nothing expected", got.token_char);
			fail_count++;
		end else begin
			want = words_due.pop_front();
			if (got.token_char !== want.token_char) begin
				$error("token_char: expected 0x%02h, got 0x%02h", want.token_char, got.token_char);
				fail_count++;
			end
			if (got.token_kind !== want.token_kind) begin
				$error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
				fail_count++;
			end
			if (got.token_end !== want.token_end) begin
				$error("token_end: expected %0d, got %0d", want.token_end, got.token_end);
				fail_count++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
				fail_count++;
			end
		end
	endtask

	task automatic push_byte(input logic [7:0] c, input logic eos);
		src_byte_t b;
		b.ch  = c;
		b.eos = eos;
		source_text = {source_text, b};
		live_bytes++;
	endtask

	task automatic push_text(input string s, input logic eos);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], eos && i == s.len() - 1);
	endtask

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 4))
			0:       return CH_TAB;
			1:       return CH_LF;
			2:       return CH_FF;
			3:       return CH_CR;
			default: return CH_SPACE;
		endcase
	endfunction

	// any byte that neither delimits nor opens a string or comment
	function automatic logic [7:0] rand_plain(input bit no_digit);
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_blank(c) || is_paren_char(c) || c == CH_QUOTE || c == CH_HASH
			|| (no_digit && is_decimal(c)));
		return c;
	endfunction

	task automatic add_fragment();
		int n;
		int r;
		src_byte_t b;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 18) begin
			push_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
			n = $urandom_range(0, 6);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0)
					push_byte(CH_DOT, 1'b0);
				else
					push_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
			end
		end else if (r < 36) begin
			push_byte(rand_plain(1'b1), 1'b0);
			n = $urandom_range(0, 7);
			repeat (n)
				push_byte(rand_plain(1'b0), 1'b0);
		end else if (r < 56) begin
			push_byte(CH_QUOTE, 1'b0);
			n = $urandom_range(0, 8);
			repeat (n) begin
				if ($urandom_range(0, 4) == 0) begin
					push_byte(CH_BSLASH, 1'b0);
					case ($urandom_range(0, 8))
						0: c = CH_LOW_N;
						1: c = CH_LOW_T;
						2: c = CH_LOW_R;
						3: c = CH_LOW_F;
						4: c = CH_LOW_V;
						5: c = CH_QUOTE;
						6: c = CH_BSLASH;
						default: c = 8'($urandom_range(0, 255));
					endcase
					push_byte(c, 1'b0);
				end else begin
					do
						c = 8'($urandom_range(0, 255));
					while (c == CH_QUOTE || c == CH_BSLASH);
					push_byte(c, 1'b0);
				end
			end
			// now and then a string is left open
			if ($urandom_range(0, 9) != 0)
				push_byte(CH_QUOTE, 1'b0);
		end else if (r < 66) begin
			push_byte($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN, 1'b0);
		end else if (r < 74) begin
			push_byte(CH_HASH, 1'b0);
			n = $urandom_range(0, 10);
			repeat (n) begin
				do
					c = 8'($urandom_range(0, 255));
				while (c == CH_LF);
				push_byte(c, 1'b0);
			end
			if ($urandom_range(0, 7) != 0)
				push_byte(CH_LF, 1'b0);
		end else if (r < 84) begin
			n = $urandom_range(1, 4);
			repeat (n)
				push_byte(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			push_byte(rand_blank(), 1'b0);
		end
		if ($urandom_range(0, 1) == 0)
			push_byte(rand_blank(), 1'b0);
		if ($urandom_range(0, 14) == 0) begin
			b = source_text.pop_back();
			b.eos = 1'b1;
			source_text = {source_text, b};
		end
	endtask

	task automatic build_stimulus();
		int target;
		// number cut by a letter, comment inside an identifier
		push_text("(7.z#q", 1'b0);
		push_byte(CH_LF, 1'b0);
		// empty string, then escapes of v, a backslash and a quote
		push_text("\"\"\"\\v\\\\\\\"k\")", 1'b0);
		// extreme bytes and vertical tab as identifier characters
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(CH_VT, 1'b0);
		push_byte(CH_CR, 1'b0);
		// flush at end of source: open number, dangling escape, open comment
		push_text("9", 1'b1);
		push_text("\"\\", 1'b1);
		push_text("#x", 1'b1);
		target = live_bytes + RANDOM_BYTES;
		while (live_bytes < target)
			add_fragment();
	endtask

	// source side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_ch.valid         <= 1'b0;
			src_ch.source_char   <= 8'd0;
			src_ch.end_of_source <= 1'b0;
			src_gap              <= 0;
			src_calm             <= 1'b0;
		end else if (!src_ch.valid || src_ch.ready) begin
			if (src_gap != 0 || source_text.size() == 0) begin
				src_ch.valid <= 1'b0;
				if (src_gap != 0)
					src_gap <= src_gap - 1;
			end else begin
				next_byte = source_text.pop_front();
				src_ch.valid         <= 1'b1;
				src_ch.source_char   <= next_byte.ch;
				src_ch.end_of_source <= next_byte.eos;
				src_gap              <= src_calm ? 0 : pick_gap();
				if ($urandom_range(0, 99) == 0)
					src_calm <= !src_calm;
			end
		end
	end

	// token side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ch.ready <= 1'b0;
			sink_stall   <= 0;
			sink_calm    <= 1'b0;
		end else if (sink_stall != 0) begin
			tok_ch.ready <= 1'b0;
			sink_stall   <= sink_stall - 1;
		end else begin
			tok_ch.ready <= 1'b1;
			if (!sink_calm && $urandom_range(0, 5) == 0)
				sink_stall <= pick_gap();
			if ($urandom_range(0, 299) == 0)
				sink_calm <= !sink_calm;
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		if (arst_n) begin
			if (tok_ch.valid && tok_ch.ready)
				check_word({tok_ch.token_char, tok_ch.token_kind, tok_ch.token_end,
					tok_ch.run_last});
			if (src_ch.valid && src_ch.ready) begin
				bytes_fed++;
				if (src_ch.end_of_source)
					flushes++;
				lex_byte(src_ch.source_char, src_ch.end_of_source);
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((src_ch.valid && src_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
				$display("sexpr_token_scanner_core regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		live_bytes    = 0;
		fail_count    = 0;
		bytes_fed     = 0;
		words_checked = 0;
		tokens_closed = 0;
		flushes       = 0;
		build_stimulus();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (source_text.size() != 0 || src_ch.valid)
			@(posedge clk);
		while (words_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (words_due.size() != 0) begin
			$error("%0d token words never arrived", words_due.size());
			fail_count++;
		end
		$display("fed %0d source bytes (%0d end-of-source flushes)", bytes_fed, flushes);
		$display("checked %0d token words closing %0d tokens, %0d mismatches",
			words_checked, tokens_closed, fail_count);
		if (fail_count == 0)
			$display("sexpr_token_scanner_core regression: pass");
		else
			$display("sexpr_token_scanner_core regression: fail");
		$finish;
	end

endmodule
